>>> rtl/core/chm_pkg.sv
`timescale 1ns / 1ps

package chm_pkg;

    // Table sizes (BUCKETS is taken as a power of two: the bucket is the key's low bits)
    localparam int BUCKETS    = 128;
    localparam int ENTRIES    = 256;
    localparam int VALUE_BITS = 32;

    localparam int KEY_BITS    = 64;
    localparam int FIELD_BITS  = 32;
    localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ENTRY_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Links and the fill count hold entry index + 1, zero meaning none
    localparam int LINK_BITS   = $clog2(ENTRIES + 1);

    // Command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HEAD  = 4'b0010,
        S_ENTRY = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // One pool entry as kept in the entry memory
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [LINK_BITS-1:0]  link;
    } t_entry;

endpackage

>>> rtl/core/chm_if.sv
`timescale 1ns / 1ps

// Request channel: one put or get per transaction
interface chm_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [chm_pkg::KEY_BITS-1:0] key;
    logic [chm_pkg::FIELD_BITS-1:0]      value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

// Response channel: one result per request
interface chm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [chm_pkg::FIELD_BITS-1:0] read_value;
    logic                           pool_full;

    modport source (output valid, found, read_value, pool_full, input ready);
    modport sink   (input valid, found, read_value, pool_full, output ready);
endinterface

>>> rtl/core/chained_hash_map.sv
`timescale 1ns / 1ps
// Flow: an accepted request reads its bucket head, then walks the chain in the entry
//   memory (one entry memory read per cycle) until a key hit or the chain's end.
// A new request is taken only in S_IDLE, after the last result has moved out; the chain
//   walk through the entry memory sets the pace, and a response that is not taken delays the next completion.
// Reset: synchronous, active low; clears bucket valid bits, fill count and handshake
//   state at once. Entry memory is not cleared and no clearing pass runs.
module chained_hash_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chm_req_if.sink     i_req,
    chm_rsp_if.source   o_rsp
);

    localparam int BB = chm_pkg::BUCKET_BITS;
    localparam int EB = chm_pkg::ENTRY_BITS;
    localparam int LB = chm_pkg::LINK_BITS;
    localparam int VB = chm_pkg::VALUE_BITS;
    localparam int KB = chm_pkg::KEY_BITS;
    localparam int FB = chm_pkg::FIELD_BITS;

    chm_pkg::t_state r_state, n_state;

    // Latched request
    logic          r_cmd;
    logic [KB-1:0] r_key;
    logic [VB-1:0] r_val, n_val;
    logic [BB-1:0] r_bucket;

    // Walk state
    logic [LB-1:0] r_head, n_head;
    logic [EB-1:0] r_ent_addr, n_ent_addr;
    logic [LB-1:0] r_count, n_count;
    logic [chm_pkg::BUCKETS-1:0] r_head_vld;

    // Result and output registers
    logic          r_res_found, n_res_found;
    logic [VB-1:0] r_res_val, n_res_val;
    logic          r_res_full, n_res_full;
    logic          r_out_valid;
    logic          r_out_found;
    logic [FB-1:0] r_out_val;
    logic          r_out_full;

    // Memory ports
    logic          head_re, head_we;
    logic [BB-1:0] head_raddr;
    logic [LB-1:0] head_rdata;
    logic          ent_re, ent_we;
    logic [EB-1:0] ent_raddr, ent_waddr;
    chm_pkg::t_entry ent_wdata, ent_rd;
    logic [$bits(chm_pkg::t_entry)-1:0] ent_rdata;

    logic [LB-1:0] head_link, ins_link;
    logic          key_hit, walk_hit, walk_miss, out_load, insert;
    logic [63:0]   val_wide;

    chm_ram #(
        .WIDTH (LB),
        .DEPTH (chm_pkg::BUCKETS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_bucket),
        .i_wdata (r_count + LB'(1)),
        .i_re    (head_re),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    chm_ram #(
        .WIDTH ($bits(chm_pkg::t_entry)),
        .DEPTH (chm_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign ent_rd     = chm_pkg::t_entry'(ent_rdata);
    // An untouched bucket reads as an empty chain
    assign head_link  = r_head_vld[r_bucket] ? head_rdata : '0;
    assign ins_link   = (r_state == chm_pkg::S_HEAD) ? head_link : r_head;
    // Shared key compare
    assign key_hit    = (ent_rd.key == r_key);
    assign head_raddr = i_req.key[BB-1:0];
    assign val_wide   = 64'(i_req.value);
    assign n_val      = val_wide[VB-1:0];
    assign out_load   = (r_state == chm_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_ent_addr  = r_ent_addr;
        n_count     = r_count;
        n_res_found = r_res_found;
        n_res_val   = r_res_val;
        n_res_full  = r_res_full;
        head_re     = 1'b0;
        head_we     = 1'b0;
        ent_re      = 1'b0;
        ent_raddr   = EB'(head_link - LB'(1));
        ent_we      = 1'b0;
        ent_waddr   = r_ent_addr;
        ent_wdata   = ent_rd;
        walk_hit    = 1'b0;
        walk_miss   = 1'b0;
        insert      = 1'b0;

        case (r_state)
            chm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    head_re = 1'b1;
                    n_state = chm_pkg::S_HEAD;
                end
            end
            chm_pkg::S_HEAD: begin
                n_head = head_link;
                if (head_link == '0) begin
                    walk_miss = 1'b1;
                end else begin
                    ent_re     = 1'b1;
                    ent_raddr  = EB'(head_link - LB'(1));
                    n_ent_addr = ent_raddr;
                    n_state    = chm_pkg::S_ENTRY;
                end
            end
            chm_pkg::S_ENTRY: begin
                if (key_hit) begin
                    walk_hit = 1'b1;
                end else if (ent_rd.link == '0) begin
                    walk_miss = 1'b1;
                end else begin
                    // Advance to the next entry of the chain
                    ent_re     = 1'b1;
                    ent_raddr  = EB'(ent_rd.link - LB'(1));
                    n_ent_addr = ent_raddr;
                end
            end
            chm_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = chm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chm_pkg::S_IDLE;
            end
        endcase

        // Hit: report value on get, overwrite value on put
        if (walk_hit) begin
            n_state     = chm_pkg::S_DONE;
            n_res_found = 1'b1;
            n_res_full  = 1'b0;
            n_res_val   = (r_cmd == chm_pkg::CMD_GET) ? ent_rd.val : '0;
            if (r_cmd == chm_pkg::CMD_PUT) begin
                ent_we        = 1'b1;
                ent_waddr     = r_ent_addr;
                ent_wdata     = ent_rd;
                ent_wdata.val = r_val;
            end
        end

        // Miss: push a new entry on a put, or flag a full pool
        if (walk_miss) begin
            n_state     = chm_pkg::S_DONE;
            n_res_found = 1'b0;
            n_res_val   = '0;
            n_res_full  = 1'b0;
            if (r_cmd == chm_pkg::CMD_PUT) begin
                if (r_count == LB'(chm_pkg::ENTRIES)) begin
                    n_res_full = 1'b1;
                end else begin
                    insert         = 1'b1;
                    ent_we         = 1'b1;
                    ent_waddr      = r_count[EB-1:0];
                    ent_wdata.key  = r_key;
                    ent_wdata.val  = r_val;
                    ent_wdata.link = ins_link;
                    head_we        = 1'b1;
                    n_count        = r_count + LB'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::S_IDLE;
            r_count     <= '0;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (insert) begin
                r_head_vld[r_bucket] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd    <= i_req.command;
            r_key    <= i_req.key;
            r_val    <= n_val;
            r_bucket <= i_req.key[BB-1:0];
        end
        r_head      <= n_head;
        r_ent_addr  <= n_ent_addr;
        r_res_found <= n_res_found;
        r_res_val   <= n_res_val;
        r_res_full  <= n_res_full;
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_val   <= FB'(64'(r_res_val));
            r_out_full  <= r_res_full;
        end
    end

    assign i_req.ready      = (r_state == chm_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.read_value = r_out_val;
    assign o_rsp.pool_full  = r_out_full;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LB'(chm_pkg::ENTRIES))
        else $error("fill count beyond pool size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.pool_full) |-> (r_count == LB'(chm_pkg::ENTRIES)))
        else $error("pool_full reported with free entries");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.read_value == '0))
        else $error("nonzero read_value without a hit");

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == chm_pkg::S_HEAD))
        else $error("accepted request did not start a bucket lookup");

endmodule

>>> rtl/core/chm_ram.sv
`timescale 1ns / 1ps

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/chm_map_checker.sv
`timescale 1ns / 1ps

module chm_map_checker
    import chm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic                  i_req_command,
    input  logic [KEY_BITS-1:0]   i_req_key,
    input  logic [FIELD_BITS-1:0] i_req_value,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic                  i_rsp_found,
    input  logic [FIELD_BITS-1:0] i_rsp_read_value,
    input  logic                  i_rsp_pool_full,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_get_hits,
    output int                    o_overwrites,
    output int                    o_rejects
);

    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] read_value;
        logic                  pool_full;
    } map_result_t;

    // Shadow copy of the table: chain heads, entry pool and fill count
    logic [LINK_BITS-1:0]  head_of  [BUCKETS];
    logic [KEY_BITS-1:0]   key_at   [ENTRIES];
    logic [VALUE_BITS-1:0] value_at [ENTRIES];
    logic [LINK_BITS-1:0]  next_of  [ENTRIES];
    int                    used_entries;
    map_result_t           expected_results[$];

    // Walk the key's chain, newest first; return entry index + 1, zero on a miss
    function automatic int lookup_entry(logic [KEY_BITS-1:0] key);
        int link;
        int steps;
        link  = int'(head_of[key[BUCKET_BITS-1:0]]);
        steps = 0;
        while (link != 0 && steps < ENTRIES) begin
            if (key_at[ENTRY_BITS'(link - 1)] == key) begin
                return link;
            end
            link = int'(next_of[ENTRY_BITS'(link - 1)]);
            steps++;
        end
        return 0;
    endfunction

    // Apply one put or get to the shadow table and return the result it causes
    function automatic map_result_t apply_request(logic cmd, logic [KEY_BITS-1:0] key,
                                                  logic [FIELD_BITS-1:0] val);
        map_result_t            res;
        int                     hit;
        logic [BUCKET_BITS-1:0] bkt;
        res = '0;
        bkt = key[BUCKET_BITS-1:0];
        hit = lookup_entry(key);
        if (cmd == CMD_GET) begin
            if (hit != 0) begin
                res.found      = 1'b1;
                res.read_value = FIELD_BITS'(value_at[ENTRY_BITS'(hit - 1)]);
                o_get_hits++;
            end
        end else if (hit != 0) begin
            value_at[ENTRY_BITS'(hit - 1)] = VALUE_BITS'(val);
            res.found                      = 1'b1;
            o_overwrites++;
        end else if (used_entries >= ENTRIES) begin
            res.pool_full = 1'b1;
            o_rejects++;
        end else begin
            // push the new entry onto the head of its chain
            key_at[ENTRY_BITS'(used_entries)]   = key;
            value_at[ENTRY_BITS'(used_entries)] = VALUE_BITS'(val);
            next_of[ENTRY_BITS'(used_entries)]  = head_of[bkt];
            head_of[bkt]                        = LINK_BITS'(used_entries + 1);
            used_entries++;
        end
        return res;
    endfunction

    // Compare one response transaction with the oldest expectation
    task automatic check_result();
        map_result_t got;
        map_result_t want;
        got = '{i_rsp_found, i_rsp_read_value, i_rsp_pool_full};
        if (expected_results.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("[%0t] ERROR: unexpected result found=%b read_value=%h pool_full=%b",
                         $time, got.found, got.read_value, got.pool_full);
            end
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                o_errors++;
                if (o_errors <= 10) begin
                    $display("[%0t] ERROR: expected found=%b read_value=%h pool_full=%b",
                             $time, want.found, want.read_value, want.pool_full);
                    $display("[%0t]        actual   found=%b read_value=%h pool_full=%b",
                             $time, got.found, got.read_value, got.pool_full);
                end
            end
        end
    endtask

    // Check results first, then queue the prediction for a new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (head_of[b]) begin
                head_of[b] = '0;
            end
            used_entries = 0;
            expected_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                check_result();
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(apply_request(i_req_command, i_req_key,
                                                         i_req_value));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/chained_hash_map_tb.sv
`timescale 1ns / 1ps

module chained_hash_map_tb;
    import chm_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = ENTRIES + 16;
    localparam int PHASE_ITEMS = 300;

    localparam logic [KEY_BITS-1:0] KEY_MIN     = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [KEY_BITS-1:0] KEY_MAX     = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic [KEY_BITS-1:0] KEY_NEG_ONE = {KEY_BITS{1'b1}};

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   puts_sent;
    int   gets_sent;
    int   map_errors;
    int   results_due;
    int   get_hits;
    int   overwrites;
    int   rejects;
    logic [KEY_BITS-1:0] known_keys[$];

    chm_req_if req_if ();
    chm_rsp_if rsp_if ();

    chained_hash_map u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    chm_map_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (req_if.valid),
        .i_req_ready      (req_if.ready),
        .i_req_command    (req_if.command),
        .i_req_key        (req_if.key),
        .i_req_value      (req_if.value),
        .i_rsp_valid      (rsp_if.valid),
        .i_rsp_ready      (rsp_if.ready),
        .i_rsp_found      (rsp_if.found),
        .i_rsp_read_value (rsp_if.read_value),
        .i_rsp_pool_full  (rsp_if.pool_full),
        .o_errors         (map_errors),
        .o_pending        (results_due),
        .o_get_hits       (get_hits),
        .o_overwrites     (overwrites),
        .o_rejects        (rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: stall the response channel at the current idle rate
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] ERROR: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drive one request, with random idle cycles ahead of it, and hold until taken
    task automatic send_op(input logic cmd, input logic [KEY_BITS-1:0] key,
                           input logic [FIELD_BITS-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.command = cmd;
        req_if.key     = key;
        req_if.value   = val;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        if (cmd == CMD_PUT) begin
            puts_sent++;
        end else begin
            gets_sent++;
        end
    endtask

    // Random traffic: mostly fresh inserts, overwrites and lookups of known keys
    task automatic random_op();
        logic                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [FIELD_BITS-1:0] val;
        int                    pick;
        val  = $urandom;
        cmd  = ($urandom_range(99) < 60) ? CMD_PUT : CMD_GET;
        pick = $urandom_range(99);
        key  = known_keys[$urandom_range(known_keys.size() - 1)];
        if (cmd == CMD_PUT) begin
            if (pick < 70) begin
                // fresh key, half of them crowded into a few buckets for long chains
                key = {$urandom, $urandom};
                if ($urandom_range(1) == 1) begin
                    key[BUCKET_BITS-1:0] = BUCKET_BITS'($urandom_range(7));
                end
                known_keys.push_back(key);
            end
        end else if (pick >= 85) begin
            key = {$urandom, $urandom};
        end else if (pick >= 75) begin
            // same bucket as a known key, most likely absent
            key[$urandom_range(KEY_BITS-1, BUCKET_BITS)] ^= 1'b1;
        end
        send_op(cmd, key, val);
    endtask

    initial begin
        req_if.valid   = 1'b0;
        req_if.command = CMD_PUT;
        req_if.key     = '0;
        req_if.value   = '0;
        i_rst_n        = 1'b0;
        tx_idle_pct    = 19;
        rx_idle_pct    = 58;
        puts_sent      = 0;
        gets_sent      = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty map, extreme keys and values, shared buckets, misses
        send_op(CMD_GET, '0, '0);
        send_op(CMD_PUT, '0, '0);
        send_op(CMD_GET, '0, '0);
        send_op(CMD_PUT, '0, '1);
        send_op(CMD_GET, '0, '0);
        send_op(CMD_PUT, KEY_MIN, 32'h1234_5678);
        send_op(CMD_PUT, KEY_MAX, 32'hA5A5_A5A5);
        send_op(CMD_PUT, KEY_NEG_ONE, 32'h5A5A_5A5A);
        send_op(CMD_GET, KEY_MAX, '0);
        send_op(CMD_GET, KEY_NEG_ONE, '0);
        send_op(CMD_GET, KEY_MIN, '0);
        send_op(CMD_GET, '0, '0);
        send_op(CMD_GET, 64'd128, '0);
        send_op(CMD_PUT, 64'd128, 32'h0000_0001);
        send_op(CMD_GET, '0, '1);
        send_op(CMD_PUT, KEY_MIN, '0);
        send_op(CMD_GET, KEY_MIN, 32'hDEAD_BEEF);
        send_op(CMD_GET, KEY_MAX ^ 64'h80, '0);
        send_op(CMD_PUT, KEY_NEG_ONE, '1);
        send_op(CMD_GET, KEY_NEG_ONE, '0);
        known_keys = {64'd0, KEY_MIN, KEY_MAX, KEY_NEG_ONE, 64'd128};

        // Random: receiver idles, then sender idles, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 58 : 0;
            rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 19 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_op();
            end
            // hold off the sender until every outstanding result is back
            @(negedge i_clk);
            req_if.valid = 1'b0;
            wait (results_due == 0);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Sent %0d puts and %0d gets over three traffic phases", puts_sent, gets_sent);
        $display("Seen %0d get hits, %0d overwrites, %0d puts refused on a full pool",
                 get_hits, overwrites, rejects);
        if (map_errors == 0 && results_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> chained_hash_map.f
rtl/core/chm_pkg.sv
rtl/core/chm_if.sv
rtl/core/chm_ram.sv
rtl/core/chained_hash_map.sv
tb/chm_map_checker.sv
tb/chained_hash_map_tb.sv
